### design/nnu_pkg.sv
// Shared types and constants for the nearest-neighbour upscaler.
// No dependencies; used by nnu_seq, nnu_out and the top level.
package nnu_pkg;

   // Field widths fixed by the interface
   localparam int PIXEL_W      = 24;
   localparam int SCALE_W      = 7;
   localparam int SRC_WIDTH_W  = 11;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 1;

   // Default sizing of the line store and the factor range
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_FACTOR_DEF = 100;

   // Register reset values
   localparam logic [SCALE_W-1:0]     SCALE_RESET = 7'd1;
   localparam logic [SRC_WIDTH_W-1:0] WIDTH_RESET = 11'd1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_WIDTH = 1'd1;

   // Input word kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_PIXEL     = 2'd0;
   localparam logic [1:0] ST_PAD       = 2'd1;
   localparam logic [1:0] ST_NOT_READY = 2'd2;
   localparam logic [1:0] ST_REJECT    = 2'd3;

   typedef struct packed {
      logic               kind;
      logic [PIXEL_W-1:0] pixel_value;
   } nnu_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [PIXEL_W-1:0] out_pixel;
      logic               end_of_row;
      logic               end_of_group;
   } nnu_rsp_type;

   // Result descriptor passed from the sequencer to the output stage
   typedef struct packed {
      logic       valid;
      logic [1:0] status;
      logic       from_mem;
      logic       eor;
      logic       eog;
   } nnu_meta_type;

endpackage

### design/nearest_neighbor_upscaler.sv
// Nearest-neighbour upscaler for 24-bit pixel rows. Load words fill a line store with one
// source row; step words then stream out each pixel repeated by the scale factor, followed
// by (output width mod 4) zero pad bytes, the padded scanline replayed factor times before
// the buffer is released. The block takes one word per clock: the sequencer updates its
// counters and issues its line store write or read in the accept cycle, the read data is
// registered in the line store and the result sits in an output register, so a word enters
// every cycle as long as the result side keeps taking words. Config writes are always
// ready; the line store needs no clearing pass after reset.
// Depends on nnu_pkg, nnu_seq, nnu_line_mem and nnu_out.
module nearest_neighbor_upscaler #(
   parameter int MAX_WIDTH  = nnu_pkg::MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = nnu_pkg::MAX_FACTOR_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nnu_pkg::nnu_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nnu_pkg::nnu_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [nnu_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nnu_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   nnu_pkg::nnu_meta_type       meta;
   logic                        out_advance;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [nnu_pkg::PIXEL_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [nnu_pkg::PIXEL_W-1:0] rd_data;

   nnu_seq #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_FACTOR (MAX_FACTOR),
      .AW         (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .out_advance (out_advance),
      .meta        (meta),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   nnu_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .DW    (nnu_pkg::PIXEL_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nnu_out u_out (
      .clock       (clock),
      .reset       (reset),
      .meta        (meta),
      .rd_data     (rd_data),
      .out_advance (out_advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

### design/nnu_line_mem.sv
// Line store: single-port-write, single-port-read synchronous RAM with a registered read port.
// Read data holds its value until the next read. No package dependencies.
module nnu_line_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/nnu_seq.sv
// Sequencer: configuration registers, row/column/repeat counters and line store addressing.
// Depends on nnu_pkg; drives nnu_line_mem and hands a result descriptor to nnu_out.
module nnu_seq #(
   parameter int MAX_WIDTH  = nnu_pkg::MAX_WIDTH_DEF,
   parameter int MAX_FACTOR = nnu_pkg::MAX_FACTOR_DEF,
   parameter int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  nnu_pkg::nnu_req_type             req_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nnu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nnu_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                             out_advance,
   output nnu_pkg::nnu_meta_type            meta,
   output logic                             wr_en,
   output logic [AW-1:0]                    wr_addr,
   output logic [nnu_pkg::PIXEL_W-1:0]      wr_data,
   output logic                             rd_en,
   output logic [AW-1:0]                    rd_addr
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = WW + 1;
   localparam int FW = $clog2(MAX_FACTOR + 1);
   localparam int FC = FW + 1;

   logic [nnu_pkg::SCALE_W-1:0]     scale_ff, scale_in;
   logic [nnu_pkg::SRC_WIDTH_W-1:0] width_ff, width_in;
   logic [WW-1:0]                   loaded_ff, loaded_in;
   logic [AW-1:0]                   column_ff, column_in;
   logic [FW-1:0]                   pix_rep_ff, pix_rep_in;
   logic [FW-1:0]                   row_rep_ff, row_rep_in;
   logic [1:0]                      pad_cnt_ff, pad_cnt_in;
   logic                            in_pad_ff, in_pad_in;
   nnu_pkg::nnu_meta_type           meta_ff, meta_in;

   logic [FW-1:0] factor;
   logic [WW-1:0] width;
   logic [FC-1:0] factor_ext;
   logic [CW-1:0] width_ext;
   logic [3:0]    pad_prod;
   logic [1:0]    pad_len;
   logic          full;
   logic          accept;
   logic [FC-1:0] pix_rep_inc;
   logic [FC-1:0] row_rep_inc;
   logic [CW-1:0] column_inc;
   logic [2:0]    pad_cnt_inc;
   logic          run_done;
   logic          last_pixel;
   logic          eor;

   assign csr_ready = 1'b1;
   assign req_ready = !meta_ff.valid || out_advance;
   assign accept    = req_valid && req_ready;

   // configuration writes
   always_comb begin
      scale_in = scale_ff;
      width_in = width_ff;
      if (csr_valid) begin
         unique case (csr_index)
            nnu_pkg::CSR_SCALE_FACTOR: scale_in = csr_data[nnu_pkg::SCALE_W-1:0];
            nnu_pkg::CSR_SOURCE_WIDTH: width_in = csr_data;
            default: ;
         endcase
      end
   end

   // effective factor and width, clamped to the supported range
   always_comb begin
      if (scale_ff == '0) begin
         factor = FW'(1);
      end else if (32'(scale_ff) > 32'(MAX_FACTOR)) begin
         factor = FW'(MAX_FACTOR);
      end else begin
         factor = FW'(scale_ff);
      end
      if (width_ff == '0) begin
         width = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width = WW'(MAX_WIDTH);
      end else begin
         width = WW'(width_ff);
      end
   end

   assign factor_ext = FC'(factor);
   assign width_ext  = CW'(width);
   // pad bytes = (width * factor) mod 4
   assign pad_prod   = {2'b00, width_ext[1:0]} * {2'b00, factor_ext[1:0]};
   assign pad_len    = pad_prod[1:0];
   assign full       = loaded_ff >= width;

   assign pix_rep_inc = FC'(pix_rep_ff) + FC'(1);
   assign row_rep_inc = FC'(row_rep_ff) + FC'(1);
   assign column_inc  = CW'(column_ff) + CW'(1);
   assign pad_cnt_inc = {1'b0, pad_cnt_ff} + 3'd1;
   assign run_done    = pix_rep_inc >= factor_ext;
   assign last_pixel  = run_done && (column_inc >= width_ext);

   // per-word counter update and result descriptor
   always_comb begin
      loaded_in  = loaded_ff;
      column_in  = column_ff;
      pix_rep_in = pix_rep_ff;
      row_rep_in = row_rep_ff;
      pad_cnt_in = pad_cnt_ff;
      in_pad_in  = in_pad_ff;
      meta_in    = '0;
      wr_en      = 1'b0;
      wr_addr    = loaded_ff[AW-1:0];
      wr_data    = req_data.pixel_value;
      rd_en      = 1'b0;
      rd_addr    = column_ff;
      eor        = 1'b0;
      if (accept) begin
         if (req_data.kind == nnu_pkg::KIND_LOAD) begin
            if (full) begin
               meta_in.valid  = 1'b1;
               meta_in.status = nnu_pkg::ST_REJECT;
            end else begin
               wr_en     = 1'b1;
               loaded_in = loaded_ff + WW'(1);
            end
         end else if (!full) begin
            meta_in.valid  = 1'b1;
            meta_in.status = nnu_pkg::ST_NOT_READY;
         end else begin
            meta_in.valid = 1'b1;
            if (!in_pad_ff) begin
               // pixel from the line store
               meta_in.status   = nnu_pkg::ST_PIXEL;
               meta_in.from_mem = 1'b1;
               rd_en            = 1'b1;
               if (run_done) begin
                  pix_rep_in = '0;
                  column_in  = AW'(column_inc);
               end else begin
                  pix_rep_in = FW'(pix_rep_inc);
               end
               if (last_pixel) begin
                  column_in  = '0;
                  pix_rep_in = '0;
                  if (pad_len != 2'd0) begin
                     in_pad_in  = 1'b1;
                     pad_cnt_in = '0;
                  end else begin
                     eor = 1'b1;
                  end
               end
            end else begin
               // trailing pad byte
               meta_in.status = nnu_pkg::ST_PAD;
               if (pad_cnt_inc >= {1'b0, pad_len}) begin
                  eor        = 1'b1;
                  in_pad_in  = 1'b0;
                  pad_cnt_in = '0;
               end else begin
                  pad_cnt_in = pad_cnt_inc[1:0];
               end
            end
            // end of scanline: count replicas, release buffer after the last
            if (eor) begin
               meta_in.eor = 1'b1;
               if (row_rep_inc >= factor_ext) begin
                  meta_in.eog = 1'b1;
                  row_rep_in  = '0;
                  loaded_in   = '0;
               end else begin
                  row_rep_in = FW'(row_rep_inc);
               end
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= nnu_pkg::SCALE_RESET;
         width_ff   <= nnu_pkg::WIDTH_RESET;
         loaded_ff  <= '0;
         column_ff  <= '0;
         pix_rep_ff <= '0;
         row_rep_ff <= '0;
         pad_cnt_ff <= '0;
         in_pad_ff  <= 1'b0;
         meta_ff    <= '0;
      end else begin
         scale_ff   <= scale_in;
         width_ff   <= width_in;
         loaded_ff  <= loaded_in;
         column_ff  <= column_in;
         pix_rep_ff <= pix_rep_in;
         row_rep_ff <= row_rep_in;
         pad_cnt_ff <= pad_cnt_in;
         in_pad_ff  <= in_pad_in;
         if (req_ready) begin
            meta_ff <= meta_in;
         end
      end
   end

   assign meta = meta_ff;

endmodule

### design/nnu_out.sv
// Output register: combines the result descriptor with line store read data.
// Depends on nnu_pkg; fed by nnu_seq and nnu_line_mem.
module nnu_out (
   input  logic                        clock,
   input  logic                        reset,
   input  nnu_pkg::nnu_meta_type       meta,
   input  logic [nnu_pkg::PIXEL_W-1:0] rd_data,
   output logic                        out_advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output nnu_pkg::nnu_rsp_type        rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   nnu_pkg::nnu_rsp_type rsp_ff, rsp_in;

   // output register free or being drained
   assign out_advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_advance) begin
         rsp_valid_in        = meta.valid;
         rsp_in.status       = meta.status;
         rsp_in.out_pixel    = meta.from_mem ? rd_data : '0;
         rsp_in.end_of_row   = meta.eor;
         rsp_in.end_of_group = meta.eog;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
